FILE: design/pba_pkg.sv
// Shared types and codes of the power-of-two block allocator.
// No dependencies; imported by every module of the block.
package pba_pkg;

    // Class code of an entry that does not start a free block
    localparam logic [4:0] NOT_FREE = 5'd31;

    // Command codes
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXHAUST = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // One entry of the start table: class of the free block and its stamp
    typedef struct packed {
        logic [4:0]  cls;
        logic [31:0] stamp;
    } t_entry;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_BUMP,
        S_TAKE,
        S_REL_CHK,
        S_MTEST,
        S_MLO,
        S_MHI,
        S_FREE
    } t_state;

endpackage

FILE: design/pba_mem.sv
// Start table memory: one write port, one read port, registered read data.
// Depends on pba_pkg for the entry type.
module pba_mem #(
    parameter int AW = 10
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pba_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output pba_pkg::t_entry o_rdata
);
    import pba_pkg::*;

    t_entry r_mem [2**AW];
    t_entry r_rdata;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read: data appears in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/power_of_two_block_allocator.sv
// Allocate: the start table is scanned when a freed block may fit, then split steps follow
// down to the order; otherwise a bump allocation, or an early error for a bad order. Release:
// a check read, then per merge level a test and one read per neighbor, also for the last
// failed test, then one write of the freed entry.
// One command at a time; busy is high from acceptance until the one-cycle o_done strobe,
// but stays low for an early error. After reset a clearing pass marks every entry below CAPACITY not free (busy high).
module power_of_two_block_allocator #(
    parameter int CAPACITY  = 1024,
    parameter int MAX_ORDER = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [3:0] i_size_order,
    input  logic [9:0] i_block_offset,
    output logic       o_done,
    output logic [9:0] o_granted_offset,
    output logic [1:0] o_status
);
    import pba_pkg::*;

    localparam int AW  = $clog2(CAPACITY);
    localparam int MW  = (AW > 10) ? AW : 10;
    localparam int XW  = ((MW > MAX_ORDER) ? MW : MAX_ORDER) + 2;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
    localparam logic [AW:0]   CAP_C = (AW+1)'(CAPACITY);

    t_state         r_state, n_state;
    logic [AW:0]    r_cnt, n_cnt;
    logic [3:0]     r_order, n_order;
    logic [XW-1:0]  r_off, n_off;
    logic [4:0]     r_cls, n_cls;
    logic [4:0]     r_best_cls, n_best_cls;
    logic [31:0]    r_best_stamp, n_best_stamp;
    logic [AW-1:0]  r_best_off, n_best_off;
    logic           r_rd_vld, n_rd_vld;
    logic [AW-1:0]  r_rd_addr, n_rd_addr;
    logic [31:0]    r_stamp, n_stamp;
    logic [AW:0]    r_bump, n_bump;
    logic [4:0]     r_cc, n_cc;
    logic           r_done, n_done;
    logic [9:0]     r_gr, n_gr;
    logic [1:0]     r_st, n_st;

    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    t_entry         mem_wdata, mem_rdata;

    logic           accept, ord_bad, rel_bad, alloc_scan;
    logic [XW-1:0]  off_in, size_in, size_ord, size_cls, split_n;
    logic [XW-1:0]  lo_addr, hi_addr, bump_sum;
    logic           lo_ok, hi_ok, merge_more, rd_hit, bump_fail;
    logic           scan_issue, scan_end, scan_hit;

    pba_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Decode the incoming transaction
    assign accept     = start && !busy;
    assign off_in     = XW'(i_block_offset);
    assign size_in    = XW'(1) << i_size_order;
    assign ord_bad    = 5'(i_size_order) > 5'(MAX_ORDER);
    assign rel_bad    = ord_bad || (off_in >= CAP_X) || (off_in + size_in > CAP_X);
    assign alloc_scan = 5'(i_size_order) < r_cc;

    // Neighbor addresses for merging and sizes for splitting
    assign size_ord   = XW'(1) << r_order;
    assign size_cls   = XW'(1) << r_cls;
    assign split_n    = XW'(1) << (r_cls - 5'd1);
    assign lo_ok      = r_off >= size_cls;
    assign lo_addr    = r_off - size_cls;
    assign hi_addr    = r_off + size_cls;
    assign hi_ok      = hi_addr < CAP_X;
    assign merge_more = {1'b0, r_cc} > ({1'b0, r_cls} + 6'd1);
    assign rd_hit     = mem_rdata.cls == r_cls;
    assign bump_sum   = XW'(r_bump) + size_ord;
    assign bump_fail  = bump_sum > CAP_X;

    // Scan of the start table for the lowest usable class, newest stamp
    assign scan_issue = r_cnt < CAP_C;
    assign scan_end   = !scan_issue && !r_rd_vld;
    assign scan_hit   = r_rd_vld && (mem_rdata.cls >= 5'(r_order)) &&
                        (mem_rdata.cls < r_cc) &&
                        ((mem_rdata.cls < r_best_cls) ||
                         ((mem_rdata.cls == r_best_cls) &&
                          (mem_rdata.stamp > r_best_stamp)));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_cnt == CAP_C - (AW+1)'(1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_ALLOC) begin
                        if (ord_bad)         n_state = S_IDLE;
                        else if (alloc_scan) n_state = S_SCAN;
                        else                 n_state = S_BUMP;
                    end else begin
                        n_state = rel_bad ? S_IDLE : S_REL_CHK;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) n_state = (r_best_cls == NOT_FREE) ? S_BUMP : S_TAKE;
            end
            S_BUMP: n_state = S_IDLE;
            S_TAKE: begin
                if (r_cls == 5'(r_order) || r_cls - 5'd1 == 5'(r_order)) n_state = S_IDLE;
            end
            S_REL_CHK: n_state = (mem_rdata.cls != NOT_FREE) ? S_IDLE : S_MTEST;
            S_MTEST: begin
                if (!merge_more)  n_state = S_FREE;
                else if (lo_ok)   n_state = S_MLO;
                else if (hi_ok)   n_state = S_MHI;
                else              n_state = S_FREE;
            end
            S_MLO: begin
                if (rd_hit)      n_state = S_MTEST;
                else if (hi_ok)  n_state = S_MHI;
                else             n_state = S_FREE;
            end
            S_MHI:  n_state = rd_hit ? S_MTEST : S_FREE;
            S_FREE: n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath, memory port and result
    always_comb begin
        n_cnt        = r_cnt;
        n_order      = r_order;
        n_off        = r_off;
        n_cls        = r_cls;
        n_best_cls   = r_best_cls;
        n_best_stamp = r_best_stamp;
        n_best_off   = r_best_off;
        n_rd_vld     = 1'b0;
        n_rd_addr    = r_rd_addr;
        n_stamp      = r_stamp;
        n_bump       = r_bump;
        n_cc         = r_cc;
        n_done       = 1'b0;
        n_gr         = '0;
        n_st         = ST_OK;
        mem_we       = 1'b0;
        mem_waddr    = r_off[AW-1:0];
        mem_wdata    = '{cls: NOT_FREE, stamp: r_stamp};
        mem_re       = 1'b0;
        mem_raddr    = r_off[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[AW-1:0];
                mem_wdata = '{cls: NOT_FREE, stamp: 32'd0};
                n_cnt     = r_cnt + (AW+1)'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_order    = i_size_order;
                    n_off      = off_in;
                    n_cls      = 5'(i_size_order);
                    n_cnt      = '0;
                    n_best_cls = NOT_FREE;
                    if (i_command == CMD_ALLOC) begin
                        if (ord_bad) begin
                            n_done = 1'b1;
                            n_st   = ST_EXHAUST;
                        end
                    end else if (rel_bad) begin
                        n_done = 1'b1;
                        n_st   = ST_REJECT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = off_in[AW-1:0];
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle, compare the returning entry
                if (scan_issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_cnt[AW-1:0];
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_cnt[AW-1:0];
                    n_cnt     = r_cnt + (AW+1)'(1);
                end
                if (scan_hit) begin
                    n_best_cls   = mem_rdata.cls;
                    n_best_stamp = mem_rdata.stamp;
                    n_best_off   = r_rd_addr;
                end
                if (scan_end) begin
                    n_cls = r_best_cls;
                    n_off = XW'(r_best_off);
                end
            end
            S_BUMP: begin
                n_done = 1'b1;
                if (bump_fail) begin
                    n_st = ST_EXHAUST;
                end else begin
                    n_gr   = 10'(r_bump);
                    n_bump = r_bump + (AW+1)'(size_ord);
                end
            end
            S_TAKE: begin
                mem_we = 1'b1;
                if (r_cls == 5'(r_order)) begin
                    // Exact fit: mark the block's entry not free
                    n_done = 1'b1;
                    n_gr   = r_off[9:0];
                end else begin
                    // Split: return the lower half, advance to the upper half
                    mem_wdata = '{cls: r_cls - 5'd1, stamp: r_stamp};
                    n_stamp   = r_stamp + 32'd1;
                    n_off     = r_off + split_n;
                    n_cls     = r_cls - 5'd1;
                    if (r_cls - 5'd1 == 5'(r_order)) begin
                        n_done = 1'b1;
                        n_gr   = n_off[9:0];
                    end
                end
            end
            S_REL_CHK: begin
                if (mem_rdata.cls != NOT_FREE) begin
                    n_done = 1'b1;
                    n_st   = ST_REJECT;
                end
            end
            S_MTEST: begin
                if (merge_more) begin
                    if (lo_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = lo_addr[AW-1:0];
                    end else if (hi_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = hi_addr[AW-1:0];
                    end
                end
            end
            S_MLO: begin
                if (rd_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = lo_addr[AW-1:0];
                    n_off     = lo_addr;
                    n_cls     = r_cls + 5'd1;
                end else if (hi_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = hi_addr[AW-1:0];
                end
            end
            S_MHI: begin
                if (rd_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = hi_addr[AW-1:0];
                    n_cls     = r_cls + 5'd1;
                end
            end
            S_FREE: begin
                mem_we    = 1'b1;
                mem_wdata = '{cls: r_cls, stamp: r_stamp};
                n_stamp   = r_stamp + 32'd1;
                if (r_cc < r_cls + 5'd1) n_cc = r_cls + 5'd1;
                n_done    = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_stamp  <= '0;
            r_bump   <= '0;
            r_cc     <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= n_rd_vld;
            r_stamp  <= n_stamp;
            r_bump   <= n_bump;
            r_cc     <= n_cc;
            r_done   <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_order      <= n_order;
        r_off        <= n_off;
        r_cls        <= n_cls;
        r_best_cls   <= n_best_cls;
        r_best_stamp <= n_best_stamp;
        r_best_off   <= n_best_off;
        r_rd_addr    <= n_rd_addr;
        r_gr         <= n_gr;
        r_st         <= n_st;
    end

    assign busy             = r_state != S_IDLE;
    assign o_done           = r_done;
    assign o_granted_offset = r_gr;
    assign o_status         = r_st;

endmodule

FILE: design/pba_checker.sv
// Port-level checks of the power-of-two block allocator, bound to the top level.
// Depends on pba_pkg for status codes.
module pba_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [9:0] o_granted_offset,
    input logic [1:0] o_status
);
    import pba_pkg::*;

    // A result is always a defined status
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ST_OK || o_status == ST_EXHAUST || o_status == ST_REJECT))
        else $error("undefined status code");

    // An error never grants an offset
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_granted_offset == 10'd0))
        else $error("nonzero offset with error status");

    // The block is free again when it shows a result
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    // An accepted transaction either keeps the block busy or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transaction dropped");

endmodule

bind power_of_two_block_allocator pba_checker u_pba_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_granted_offset (o_granted_offset),
    .o_status         (o_status)
);
